/* rtl/sri_pkg.sv */
package sri_pkg;

    // Default coordinate width; the top level hands the parameter down.
    localparam int COORD_WIDTH_DEF = 16;

    // One lane per rectangle edge; lane 0 also serves the plain segment test.
    localparam int NUM_LANES = 4;

    // Stage load strobes shared by all lanes.
    typedef struct packed {
        logic ld_s1;
        logic ld_s2;
        logic ld_s3;
    } sri_ctl_t;

endpackage

/* rtl/sri_lane.sv */
// One segment-versus-segment test: differences, products, cross signs.
module sri_lane #(
    parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  sri_pkg::sri_ctl_t             ctl,
    input  logic signed [COORD_WIDTH-1:0] ax1,
    input  logic signed [COORD_WIDTH-1:0] ay1,
    input  logic signed [COORD_WIDTH-1:0] ax2,
    input  logic signed [COORD_WIDTH-1:0] ay2,
    input  logic signed [COORD_WIDTH-1:0] bx1,
    input  logic signed [COORD_WIDTH-1:0] by1,
    input  logic signed [COORD_WIDTH-1:0] bx2,
    input  logic signed [COORD_WIDTH-1:0] by2,
    output logic                          miss
);

    localparam int DW = COORD_WIDTH + 1;   // difference width
    localparam int PW = 2 * DW;            // product width
    localparam int CW = PW + 1;            // cross product width

    // Side 0 takes segment b as base, side 1 takes segment a.
    logic signed [COORD_WIDTH-1:0] base_x1 [2];
    logic signed [COORD_WIDTH-1:0] base_y1 [2];
    logic signed [COORD_WIDTH-1:0] base_x2 [2];
    logic signed [COORD_WIDTH-1:0] base_y2 [2];
    logic signed [COORD_WIDTH-1:0] oth_x1  [2];
    logic signed [COORD_WIDTH-1:0] oth_y1  [2];
    logic signed [COORD_WIDTH-1:0] oth_x2  [2];
    logic signed [COORD_WIDTH-1:0] oth_y2  [2];

    assign base_x1[0] = bx1;
    assign base_y1[0] = by1;
    assign base_x2[0] = bx2;
    assign base_y2[0] = by2;
    assign oth_x1[0]  = ax1;
    assign oth_y1[0]  = ay1;
    assign oth_x2[0]  = ax2;
    assign oth_y2[0]  = ay2;
    assign base_x1[1] = ax1;
    assign base_y1[1] = ay1;
    assign base_x2[1] = ax2;
    assign base_y2[1] = ay2;
    assign oth_x1[1]  = bx1;
    assign oth_y1[1]  = by1;
    assign oth_x2[1]  = bx2;
    assign oth_y2[1]  = by2;

    logic signed [DW-1:0] dx_reg  [2];
    logic signed [DW-1:0] dy_reg  [2];
    logic signed [DW-1:0] rx1_reg [2];
    logic signed [DW-1:0] ry1_reg [2];
    logic signed [DW-1:0] rx2_reg [2];
    logic signed [DW-1:0] ry2_reg [2];

    // Products: [0] dx*ry1, [1] dy*rx1, [2] dx*ry2, [3] dy*rx2
    logic signed [PW-1:0] prod_reg [2][4];

    // Cross product sign per end point: [0] first end, [1] second end
    logic                 neg_reg  [2][2];
    logic                 nz_reg   [2][2];

    logic [1:0]           side_miss;

    genvar s;
    generate
        for (s = 0; s < 2; s++) begin : g_side
            logic signed [CW-1:0] cross0;
            logic signed [CW-1:0] cross1;

            always_ff @(posedge clk)
            begin
                if (ctl.ld_s1)
                begin
                    dx_reg[s]  <= DW'(base_x2[s]) - DW'(base_x1[s]);
                    dy_reg[s]  <= DW'(base_y2[s]) - DW'(base_y1[s]);
                    rx1_reg[s] <= DW'(oth_x1[s]) - DW'(base_x1[s]);
                    ry1_reg[s] <= DW'(oth_y1[s]) - DW'(base_y1[s]);
                    rx2_reg[s] <= DW'(oth_x2[s]) - DW'(base_x1[s]);
                    ry2_reg[s] <= DW'(oth_y2[s]) - DW'(base_y1[s]);
                end
            end

            always_ff @(posedge clk)
            begin
                if (ctl.ld_s2)
                begin
                    prod_reg[s][0] <= PW'(dx_reg[s]) * PW'(ry1_reg[s]);
                    prod_reg[s][1] <= PW'(dy_reg[s]) * PW'(rx1_reg[s]);
                    prod_reg[s][2] <= PW'(dx_reg[s]) * PW'(ry2_reg[s]);
                    prod_reg[s][3] <= PW'(dy_reg[s]) * PW'(rx2_reg[s]);
                end
            end

            assign cross0 = CW'(prod_reg[s][0]) - CW'(prod_reg[s][1]);
            assign cross1 = CW'(prod_reg[s][2]) - CW'(prod_reg[s][3]);

            always_ff @(posedge clk)
            begin
                if (ctl.ld_s3)
                begin
                    neg_reg[s][0] <= cross0[CW-1];
                    nz_reg[s][0]  <= |cross0;
                    neg_reg[s][1] <= cross1[CW-1];
                    nz_reg[s][1]  <= |cross1;
                end
            end

            // Both ends strictly on the same side of the base: no crossing.
            assign side_miss[s] = nz_reg[s][0] && nz_reg[s][1]
                                  && (neg_reg[s][0] == neg_reg[s][1]);
        end
    endgenerate

    assign miss = |side_miss;

endmodule

/* rtl/sri_merge.sv */
// Combine lane results into the final hit flag and hold it for the receiver.
module sri_merge (
    input  logic                          clk,
    input  logic                          ld,
    input  logic                          mode,
    input  logic [sri_pkg::NUM_LANES-1:0] lane_miss,
    output logic                          hit
);

    logic hit_reg;
    logic hit_next;

    // Segment mode looks at lane 0 only; rectangle mode ORs all edges.
    assign hit_next = mode ? (|(~lane_miss)) : !lane_miss[0];

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            hit_reg <= hit_next;
        end
    end

    assign hit = hit_reg;

endmodule

/* rtl/segment_rect_intersection_test.sv */
// Segment / rectangle intersection test on signed coordinates.
//
// Input channel (in_valid / in_stall): one transfer carries a mode bit and
// eight coordinates. Mode 0 tests segment P against segment Q; mode 1 tests
// the rectangle left=p_x1, top=p_y1, right=p_x2, bottom=p_y2 against Q.
// Output channel (out_valid / out_stall): one transfer per input, carrying
// hit, in input order.
//
// Four lanes run the segment test on the four rectangle edges side by side
// (lane 0 takes segment P in mode 0); each lane spends three register stages
// on differences, multipliers and cross product signs, and the merge stage
// ORs the lanes (lane 0 alone in mode 0) into the output register, from
// which hit and out_valid come. Throughput is one item per cycle while the
// receiver does not stall, set by the fully pipelined multipliers of each lane.
// Reset clears all stage valid bits; no item is in flight afterwards.
// When the receiver stalls, the result holds in the output register while
// earlier stages keep filling; in_stall rises only once the stage behind
// the input is occupied and cannot advance.
module segment_rect_intersection_test #(
    parameter int COORD_WIDTH = sri_pkg::COORD_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic signed [COORD_WIDTH-1:0] p_x1,
    input  logic signed [COORD_WIDTH-1:0] p_y1,
    input  logic signed [COORD_WIDTH-1:0] p_x2,
    input  logic signed [COORD_WIDTH-1:0] p_y2,
    input  logic signed [COORD_WIDTH-1:0] q_x1,
    input  logic signed [COORD_WIDTH-1:0] q_y1,
    input  logic signed [COORD_WIDTH-1:0] q_x2,
    input  logic signed [COORD_WIDTH-1:0] q_y2,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          hit
);

    localparam int NL = sri_pkg::NUM_LANES;

    sri_pkg::sri_ctl_t ctl;
    logic              ld_out;

    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic s3_valid_reg, s3_valid_next;
    logic out_valid_reg, out_valid_next;

    logic mode_s1_reg;
    logic mode_s2_reg;
    logic mode_s3_reg;

    logic [NL-1:0] lane_miss;

    // Edge end points per lane, all tested against Q.
    logic signed [COORD_WIDTH-1:0] e_x1 [NL];
    logic signed [COORD_WIDTH-1:0] e_y1 [NL];
    logic signed [COORD_WIDTH-1:0] e_x2 [NL];
    logic signed [COORD_WIDTH-1:0] e_y2 [NL];

    // Lane 0: top edge, or segment P itself in segment mode.
    assign e_x1[0] = p_x1;
    assign e_y1[0] = p_y1;
    assign e_x2[0] = p_x2;
    assign e_y2[0] = mode ? p_y1 : p_y2;
    // Lane 1: right edge
    assign e_x1[1] = p_x2;
    assign e_y1[1] = p_y1;
    assign e_x2[1] = p_x2;
    assign e_y2[1] = p_y2;
    // Lane 2: bottom edge
    assign e_x1[2] = p_x2;
    assign e_y1[2] = p_y2;
    assign e_x2[2] = p_x1;
    assign e_y2[2] = p_y2;
    // Lane 3: left edge
    assign e_x1[3] = p_x1;
    assign e_y1[3] = p_y2;
    assign e_x2[3] = p_x1;
    assign e_y2[3] = p_y1;

    // Pipeline advance: a stage loads when its source holds an item and the
    // stage is empty or moving on in the same cycle.
    assign ld_out     = s3_valid_reg && (!out_valid_reg || !out_stall);
    assign ctl.ld_s3  = s2_valid_reg && (!s3_valid_reg || ld_out);
    assign ctl.ld_s2  = s1_valid_reg && (!s2_valid_reg || ctl.ld_s3);
    assign in_stall   = s1_valid_reg && !ctl.ld_s2;
    assign ctl.ld_s1  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next  = ctl.ld_s1 || (s1_valid_reg && !ctl.ld_s2);
        s2_valid_next  = ctl.ld_s2 || (s2_valid_reg && !ctl.ld_s3);
        s3_valid_next  = ctl.ld_s3 || (s3_valid_reg && !ld_out);
        out_valid_next = ld_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            s3_valid_reg  <= s3_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Carry the mode bit alongside the lane stages.
    always_ff @(posedge clk)
    begin
        if (ctl.ld_s1)
        begin
            mode_s1_reg <= mode;
        end
        if (ctl.ld_s2)
        begin
            mode_s2_reg <= mode_s1_reg;
        end
        if (ctl.ld_s3)
        begin
            mode_s3_reg <= mode_s2_reg;
        end
    end

    genvar l;
    generate
        for (l = 0; l < NL; l++) begin : g_lane
            sri_lane #(
                .COORD_WIDTH (COORD_WIDTH)
            ) u_lane (
                .clk  (clk),
                .ctl  (ctl),
                .ax1  (e_x1[l]),
                .ay1  (e_y1[l]),
                .ax2  (e_x2[l]),
                .ay2  (e_y2[l]),
                .bx1  (q_x1),
                .by1  (q_y1),
                .bx2  (q_x2),
                .by2  (q_y2),
                .miss (lane_miss[l])
            );
        end
    endgenerate

    sri_merge u_merge (
        .clk       (clk),
        .ld        (ld_out),
        .mode      (mode_s3_reg),
        .lane_miss (lane_miss),
        .hit       (hit)
    );

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_stall_only_when_s1_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg
    ) else $error("input stalled with first stage empty");

    a_full_pipe_backpressure: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && s2_valid_reg && s3_valid_reg && out_valid_reg && out_stall)
            |-> in_stall
    ) else $error("input taken while every stage is blocked");

    a_s3_load_sets_valid: assert property (
        @(posedge clk) disable iff (!rst_n)
        ctl.ld_s3 |=> s3_valid_reg
    ) else $error("stage three lost an item");

    a_out_drains: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_stall && !s3_valid_reg) |=> !out_valid_reg
    ) else $error("result repeated after transfer");
`endif

endmodule

/* bench/segment_rect_intersection_test_tb.sv */
`timescale 1ns / 100ps

localparam int CW = sri_pkg::COORD_WIDTH_DEF;

typedef logic signed [CW-1:0] coord_t;

// One collision test as it crosses the input channel.
typedef struct {
    logic   mode;
    coord_t p_x1;
    coord_t p_y1;
    coord_t p_x2;
    coord_t p_y2;
    coord_t q_x1;
    coord_t q_y1;
    coord_t q_x2;
    coord_t q_y2;
} shape_test_t;

typedef struct {
    shape_test_t test;
    logic        hit;
} hit_expect_t;

// True when the base segment leaves both points strictly on one side.
function automatic bit same_side(longint bx1, longint by1, longint bx2, longint by2,
                                 longint ox1, longint oy1, longint ox2, longint oy2);
    longint dx;
    longint dy;
    longint c1;
    longint c2;
    dx = bx2 - bx1;
    dy = by2 - by1;
    c1 = dx * (oy1 - by1) - dy * (ox1 - bx1);
    c2 = dx * (oy2 - by1) - dy * (ox2 - bx1);
    return (c1 > 0 && c2 > 0) || (c1 < 0 && c2 < 0);
endfunction

function automatic bit segments_touch(longint ax1, longint ay1, longint ax2, longint ay2,
                                      longint bx1, longint by1, longint bx2, longint by2);
    if (same_side(bx1, by1, bx2, by2, ax1, ay1, ax2, ay2))
        return 1'b0;
    if (same_side(ax1, ay1, ax2, ay2, bx1, by1, bx2, by2))
        return 1'b0;
    return 1'b1;
endfunction

function automatic logic expected_hit(shape_test_t t);
    longint l;
    longint tp;
    longint r;
    longint b;
    longint qx1;
    longint qy1;
    longint qx2;
    longint qy2;
    l   = longint'(t.p_x1);
    tp  = longint'(t.p_y1);
    r   = longint'(t.p_x2);
    b   = longint'(t.p_y2);
    qx1 = longint'(t.q_x1);
    qy1 = longint'(t.q_y1);
    qx2 = longint'(t.q_x2);
    qy2 = longint'(t.q_y2);
    if (t.mode == 1'b0)
        return segments_touch(l, tp, r, b, qx1, qy1, qx2, qy2);
    // Rectangle: OR of all its edges, corners taken as given.
    return segments_touch(l, tp, r, tp, qx1, qy1, qx2, qy2)
        || segments_touch(r, tp, r, b, qx1, qy1, qx2, qy2)
        || segments_touch(r, b, l, b, qx1, qy1, qx2, qy2)
        || segments_touch(l, b, l, tp, qx1, qy1, qx2, qy2);
endfunction

class hit_scoreboard;
    hit_expect_t pending_hits[$];
    int          mismatches;
    int          results_seen;
    int          hits_seen;
    int          misses_seen;

    function new();
        mismatches   = 0;
        results_seen = 0;
        hits_seen    = 0;
        misses_seen  = 0;
    endfunction

    function int outstanding();
        return pending_hits.size();
    endfunction

    function void note_test(shape_test_t t);
        hit_expect_t e;
        e.test = t;
        e.hit  = expected_hit(t);
        pending_hits.push_back(e);
    endfunction

    function void check_result(logic got);
        hit_expect_t e;
        results_seen++;
        if (got === 1'b1)
            hits_seen++;
        else
            misses_seen++;
        if (pending_hits.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("MISMATCH: result hit=%0b with no test outstanding", got);
            return;
        end
        e = pending_hits.pop_front();
        if (got !== e.hit)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("MISMATCH: mode=%0b P=(%0d,%0d)-(%0d,%0d) Q=(%0d,%0d)-(%0d,%0d)",
                         e.test.mode, e.test.p_x1, e.test.p_y1, e.test.p_x2, e.test.p_y2,
                         e.test.q_x1, e.test.q_y1, e.test.q_x2, e.test.q_y2);
                $display("          expected hit=%0b got hit=%0b", e.hit, got);
            end
        end
    endfunction
endclass

module segment_rect_intersection_test_tb;

    localparam int CMIN = -(2 ** (CW - 1));
    localparam int CMAX = (2 ** (CW - 1)) - 1;

    // Random tests per idle mix, and the overall cycle budget.
    localparam int TESTS_PER_PHASE = 240;
    localparam int NUM_PHASES      = 4;
    localparam int CYCLE_LIMIT     = 400000;
    // Margin kept after the last result has come back.
    localparam int SETTLE_CYCLES   = 12;

    logic   clk;
    logic   rst_n     = 1'b0;
    logic   in_valid  = 1'b0;
    logic   in_stall;
    logic   mode      = 1'b0;
    coord_t p_x1      = '0;
    coord_t p_y1      = '0;
    coord_t p_x2      = '0;
    coord_t p_y2      = '0;
    coord_t q_x1      = '0;
    coord_t q_y1      = '0;
    coord_t q_x2      = '0;
    coord_t q_y2      = '0;
    logic   out_valid;
    logic   out_stall = 1'b0;
    logic   hit;

    // Percent chance per cycle that the sender idles / the receiver stalls.
    int idle_pct  = 0;
    int stall_pct = 0;

    int directed_sent = 0;
    int random_sent   = 0;
    int rect_sent     = 0;

    hit_scoreboard hit_sb = new();

    shape_test_t directed_tests[$];

    segment_rect_intersection_test u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .mode      (mode),
        .p_x1      (p_x1),
        .p_y1      (p_y1),
        .p_x2      (p_x2),
        .p_y2      (p_y2),
        .q_x1      (q_x1),
        .q_y1      (q_y1),
        .q_x2      (q_x2),
        .q_y2      (q_y2),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .hit       (hit)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: redraw the stall at every falling edge.
    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < stall_pct);

    // Result monitor: a transfer happens when valid is high and stall low at the edge.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            hit_sb.check_result(hit);
    end

    // Watchdog: end the run if the handshakes never complete.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding",
                 CYCLE_LIMIT, hit_sb.outstanding());
        $display("status: fail");
        $finish;
    end

    function automatic shape_test_t make_test(int m, int a, int b, int c,
                                              int d, int e, int f, int g,
                                              int h);
        shape_test_t t;
        t.mode = 1'(m);
        t.p_x1 = coord_t'(a);
        t.p_y1 = coord_t'(b);
        t.p_x2 = coord_t'(c);
        t.p_y2 = coord_t'(d);
        t.q_x1 = coord_t'(e);
        t.q_y1 = coord_t'(f);
        t.q_x2 = coord_t'(g);
        t.q_y2 = coord_t'(h);
        return t;
    endfunction

    // Coordinate drawn from full range, a small grid, or the corner values.
    function automatic coord_t rand_coord(int kind);
        case (kind)
            0: return coord_t'($urandom);
            1: return coord_t'($signed($urandom_range(0, 16)) - 8);
            default:
            begin
                case ($urandom_range(0, 4))
                    0: return coord_t'(CMIN);
                    1: return coord_t'(CMAX);
                    2: return coord_t'(0);
                    3: return coord_t'(-1);
                    default: return coord_t'(1);
                endcase
            end
        endcase
    endfunction

    function automatic coord_t span(int lo, int hi);
        return coord_t'(int'($urandom_range(0, hi - lo)) + lo);
    endfunction

    function automatic shape_test_t random_test();
        shape_test_t t;
        int          shape;
        int          kind;
        int          bx;
        int          by;
        int          dx;
        int          dy;
        int          swap;
        coord_t      tmp;
        shape = $urandom_range(0, 99);
        if (shape < 30)
        begin
            // Rectangle near the segment: inside, crossing or clear of it.
            t.mode = 1'b1;
            t.p_x1 = span(-100, 0);
            t.p_y1 = span(-100, 0);
            t.p_x2 = span(1, 100);
            t.p_y2 = span(1, 100);
            swap = $urandom_range(0, 7);
            if (swap == 0)
            begin
                tmp    = t.p_x1;
                t.p_x1 = t.p_x2;
                t.p_x2 = tmp;
            end
            else if (swap == 1)
            begin
                tmp    = t.p_y1;
                t.p_y1 = t.p_y2;
                t.p_y2 = tmp;
            end
            t.q_x1 = span(-150, 150);
            t.q_y1 = span(-150, 150);
            t.q_x2 = span(-150, 150);
            t.q_y2 = span(-150, 150);
        end
        else if (shape < 42)
        begin
            // Both segments on one line: every point is base plus a multiple
            // of one direction.
            bx = $urandom_range(0, 2000) - 1000;
            by = $urandom_range(0, 2000) - 1000;
            dx = $urandom_range(0, 40) - 20;
            dy = $urandom_range(0, 40) - 20;
            t.mode = 1'b0;
            kind   = $urandom_range(0, 60) - 30;
            t.p_x1 = coord_t'(bx + dx * kind);
            t.p_y1 = coord_t'(by + dy * kind);
            kind   = $urandom_range(0, 60) - 30;
            t.p_x2 = coord_t'(bx + dx * kind);
            t.p_y2 = coord_t'(by + dy * kind);
            kind   = $urandom_range(0, 60) - 30;
            t.q_x1 = coord_t'(bx + dx * kind);
            t.q_y1 = coord_t'(by + dy * kind);
            kind   = $urandom_range(0, 60) - 30;
            t.q_x2 = coord_t'(bx + dx * kind);
            t.q_y2 = coord_t'(by + dy * kind);
        end
        else
        begin
            if (shape < 72)
                kind = 0;
            else if (shape < 92)
                kind = 1;
            else
                kind = 2;
            t.mode = 1'($urandom_range(0, 1));
            t.p_x1 = rand_coord(kind);
            t.p_y1 = rand_coord(kind);
            t.p_x2 = rand_coord(kind);
            t.p_y2 = rand_coord(kind);
            t.q_x1 = rand_coord(kind);
            t.q_y1 = rand_coord(kind);
            t.q_x2 = rand_coord(kind);
            t.q_y2 = rand_coord(kind);
        end
        return t;
    endfunction

    // Enter at a falling edge; leave at the falling edge after the transfer.
    task automatic send_test(shape_test_t t);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        mode     <= t.mode;
        p_x1     <= t.p_x1;
        p_y1     <= t.p_y1;
        p_x2     <= t.p_x2;
        p_y2     <= t.p_y2;
        q_x1     <= t.q_x1;
        q_y1     <= t.q_y1;
        q_x2     <= t.q_x2;
        q_y2     <= t.q_y2;
        // Hold the payload until the block takes it.
        do
            @(posedge clk);
        while (in_stall);
        hit_sb.note_test(t);
        if (t.mode)
            rect_sent++;
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain_results();
        in_valid <= 1'b0;
        while (hit_sb.outstanding() > 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        // Segment against segment.
        directed_tests.push_back(make_test(0, -10, -10, 10, 10, -10, 10, 10, -10));
        directed_tests.push_back(make_test(0, 0, 0, 10, 0, 0, 5, 10, 5));
        // Collinear but apart still reports a hit.
        directed_tests.push_back(make_test(0, 0, 0, 2, 0, 5, 0, 9, 0));
        directed_tests.push_back(make_test(0, 0, 0, 5, 5, 3, 3, 8, 8));
        // Zero-length segments, on and off the other line.
        directed_tests.push_back(make_test(0, 3, 0, 3, 0, 0, 0, 6, 0));
        directed_tests.push_back(make_test(0, 3, 4, 3, 4, 0, 0, 6, 0));
        directed_tests.push_back(make_test(0, 1, 2, 1, 2, 7, -3, 7, -3));
        // Shared endpoint and T junction.
        directed_tests.push_back(make_test(0, 0, 0, 5, 5, 5, 5, 9, 0));
        directed_tests.push_back(make_test(0, 0, 0, 10, 0, 5, 0, 5, 7));
        // Coordinate extremes.
        directed_tests.push_back(make_test(0, CMIN, CMIN, CMAX, CMAX, CMIN, CMAX, CMAX, CMIN));
        directed_tests.push_back(make_test(0, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN));
        directed_tests.push_back(make_test(0, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        directed_tests.push_back(make_test(0, CMIN, CMAX, CMAX, CMAX, CMIN, CMIN, CMAX, CMIN));
        directed_tests.push_back(make_test(0, CMIN, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMAX));
        // Rectangle against segment; a segment wholly inside is a miss.
        directed_tests.push_back(make_test(1, -10, -10, 10, 10, -2, -2, 3, 3));
        directed_tests.push_back(make_test(1, -10, -10, 10, 10, 0, 0, 20, 0));
        directed_tests.push_back(make_test(1, -10, -10, 10, 10, -20, 0, 20, 0));
        directed_tests.push_back(make_test(1, -10, -10, 10, 10, 20, 20, 30, 25));
        // Edges given in reverse order are taken as they are.
        directed_tests.push_back(make_test(1, 10, 10, -10, -10, 0, 0, 20, 0));
        directed_tests.push_back(make_test(1, 5, 5, 5, 5, 0, 0, 10, 10));
        directed_tests.push_back(make_test(1, 0, 0, 10, 10, 20, 0, 30, 0));
        directed_tests.push_back(make_test(1, CMIN, CMIN, CMAX, CMAX, 0, 0, 1, 1));
        directed_tests.push_back(make_test(1, CMIN, CMIN, CMAX, CMAX, CMIN, 0, CMAX, 0));
        directed_tests.push_back(make_test(1, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX));
        directed_tests.push_back(make_test(1, CMAX, CMIN, CMIN, CMAX, CMIN, CMIN, CMAX, CMAX));

        // Hold reset, release on a falling edge.
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed tests back to back with no idling on either side.
        foreach (directed_tests[i])
        begin
            send_test(directed_tests[i]);
            directed_sent++;
        end
        drain_results();

        // Random tests under each idle mix; the sender pauses for a full drain
        // between mixes.
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 57;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 57;
                end
                default:
                begin
                    idle_pct  = 15;
                    stall_pct = 15;
                end
            endcase
            for (int n = 0; n < TESTS_PER_PHASE; n++)
            begin
                send_test(random_test());
                random_sent++;
            end
            drain_results();
        end

        $display("ran %0d directed and %0d random tests (%0d rectangle), %0d hits, %0d misses",
                 directed_sent, random_sent, rect_sent, hit_sb.hits_seen, hit_sb.misses_seen);
        $display("idle mixes: none, sender 57%%, receiver 57%%, both 15%%; %0d mismatches",
                 hit_sb.mismatches);
        if (hit_sb.mismatches == 0 && hit_sb.outstanding() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
